// ===== src/kws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe weight sampler package
// Shared sizes, codes and the command and status bundles that pass between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package kws_pkg;

   localparam int MAX_KEYFRAMES = 256;
   localparam int MAX_TARGETS   = 8;

   localparam int KEY_W    = $clog2(MAX_KEYFRAMES);
   localparam int TGT_W    = $clog2(MAX_TARGETS);
   localparam int WADDR_W  = KEY_W + TGT_W;

   localparam int FUNC_W   = 2;
   localparam int KIDX_W   = 8;
   localparam int TIDX_W   = 3;
   localparam int TIME_W   = 32;
   localparam int WEIGHT_W = 32;
   localparam int FRAC_W   = 16;
   localparam int NKEY_W   = 9;
   localparam int NTGT_W   = 4;
   localparam int CSR_W    = 9;
   localparam int DCNT_W   = $clog2(FRAC_W);

   localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(FRAC_W - 1);

   // Function codes of an input item.
   localparam logic [FUNC_W-1:0] FUNC_LOAD_TIME   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_WEIGHT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE      = 2'd2;

   // Register indexes.
   localparam logic CSR_NUM_KEYFRAMES = 1'b0;
   localparam logic CSR_NUM_TARGETS   = 1'b1;

   typedef enum logic [1:0] {
      TADDR_FIRST,
      TADDR_LAST,
      TADDR_SCAN
   } taddr_sel_type;

   typedef struct packed {
      logic          load_time;
      logic          load_weight;
      logic          capture;
      logic          keep_first;
      taddr_sel_type taddr_sel;
      logic          classify;
      logic          scan_next;
      logic          div_init;
      logic          div_step;
      logic          tgt_clear;
      logic          w_sel_hi;
      logic          latch_a;
      logic          latch_diff;
      logic          mul;
      logic          out_load;
      logic          tgt_next;
   } kws_cmd_type;

   typedef struct packed {
      logic interp;
      logic scan_hit;
      logic div_done;
      logic last_target;
      logic out_free;
   } kws_status_type;

endpackage

// ===== src/kws_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe weight sampler channels
// Valid/ready channel bundles for request items and result items.
// ----------------------------------------------------------------------------
interface kws_req_if import kws_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FUNC_W-1:0]          func;
   logic [KIDX_W-1:0]          key_index;
   logic [TIDX_W-1:0]          target_index;
   logic [TIME_W-1:0]          time_value;
   logic signed [WEIGHT_W-1:0] weight_value;

   modport source (
      output valid, func, key_index, target_index, time_value, weight_value,
      input  ready
   );
   modport sink (
      input  valid, func, key_index, target_index, time_value, weight_value,
      output ready
   );
endinterface

interface kws_rsp_if import kws_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [WEIGHT_W-1:0] weight_out;
   logic [TIDX_W-1:0]          target_out;
   logic                       last;

   modport source (
      output valid, weight_out, target_out, last,
      input  ready
   );
   modport sink (
      input  valid, weight_out, target_out, last,
      output ready
   );
endinterface

// ===== src/kws_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe weight sampler datapath
// Keyframe memories, search registers, fraction divider, interpolation
// multiplier and the result register.
// ----------------------------------------------------------------------------
module kws_datapath import kws_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [CSR_W-1:0]           csr_write_data,
   input  logic [KIDX_W-1:0]          req_key_index,
   input  logic [TIDX_W-1:0]          req_target_index,
   input  logic [TIME_W-1:0]          req_time_value,
   input  logic signed [WEIGHT_W-1:0] req_weight_value,
   input  kws_cmd_type                cmd,
   output kws_status_type             status,
   kws_rsp_if.source                  rsp_ch
);

   logic [TIME_W-1:0]   times_mem [MAX_KEYFRAMES];
   logic [WEIGHT_W-1:0] weights_mem [MAX_KEYFRAMES * MAX_TARGETS];

   logic [KEY_W-1:0]  key_last_ff, key_last_in;
   logic [TGT_W-1:0]  tgt_last_ff, tgt_last_in;
   logic [NKEY_W-1:0] nkey_value;
   logic [NTGT_W-1:0] ntgt_value;

   logic [TIME_W-1:0] tdata_ff, query_ff, t0_ff, prev_ff, rem_ff, den_ff;
   logic [KEY_W-1:0]  taddr, scan_idx_ff, lo_ff, hi_ff;
   logic [TGT_W-1:0]  tgt_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [DCNT_W-1:0] div_cnt_ff;
   logic [WEIGHT_W-1:0] wdata_ff;
   logic [WADDR_W-1:0]  waddr;

   logic le_first, ge_last;
   logic [TIME_W:0] rem_shift;
   logic            rem_fits;

   logic signed [WEIGHT_W-1:0]          a_ff;
   logic signed [WEIGHT_W:0]            diff_ff;
   logic signed [WEIGHT_W+FRAC_W+1:0]   prod_ff;
   logic signed [WEIGHT_W+FRAC_W+1:0]   prod_shift;
   logic signed [WEIGHT_W+1:0]          result;

   logic                       rsp_valid_ff;
   logic signed [WEIGHT_W-1:0] weight_out_ff;
   logic [TIDX_W-1:0]          target_out_ff;
   logic                       last_ff;

   // Register values are clamped on write to the last usable index.
   assign nkey_value = csr_write_data[NKEY_W-1:0];
   assign ntgt_value = csr_write_data[NTGT_W-1:0];

   always_comb begin
      key_last_in = key_last_ff;
      tgt_last_in = tgt_last_ff;
      if (csr_write_enable && csr_index == CSR_NUM_KEYFRAMES) begin
         if (nkey_value == '0) begin
            key_last_in = '0;
         end else if (nkey_value > NKEY_W'(MAX_KEYFRAMES)) begin
            key_last_in = KEY_W'(MAX_KEYFRAMES - 1);
         end else begin
            key_last_in = KEY_W'(nkey_value - NKEY_W'(1));
         end
      end
      if (csr_write_enable && csr_index == CSR_NUM_TARGETS) begin
         if (ntgt_value == '0) begin
            tgt_last_in = '0;
         end else if (ntgt_value > NTGT_W'(MAX_TARGETS)) begin
            tgt_last_in = TGT_W'(MAX_TARGETS - 1);
         end else begin
            tgt_last_in = TGT_W'(ntgt_value - NTGT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_last_ff <= '0;
         tgt_last_ff <= '0;
      end else begin
         key_last_ff <= key_last_in;
         tgt_last_ff <= tgt_last_in;
      end
   end

   // Time memory: one write port for loads, one registered read port.
   always_comb begin
      case (cmd.taddr_sel)
         TADDR_FIRST: taddr = '0;
         TADDR_LAST:  taddr = key_last_ff;
         TADDR_SCAN:  taddr = scan_idx_ff;
         default:     taddr = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_time) begin
         times_mem[KEY_W'(req_key_index)] <= req_time_value;
      end
      tdata_ff <= times_mem[taddr];
   end

   // Weight memory, addressed as key * MAX_TARGETS + target.
   assign waddr = {(cmd.w_sel_hi ? hi_ff : lo_ff), tgt_ff};

   always_ff @(posedge clock) begin
      if (cmd.load_weight) begin
         weights_mem[{KEY_W'(req_key_index), TGT_W'(req_target_index)}] <=
            req_weight_value;
      end
      wdata_ff <= weights_mem[waddr];
   end

   // Search.
   assign le_first = (query_ff <= t0_ff);
   assign ge_last  = (query_ff >= tdata_ff);

   // One restoring division step: the remainder always stays below the divisor.
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_fits  = (rem_shift >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         query_ff <= req_time_value;
      end
      if (cmd.keep_first) begin
         t0_ff <= tdata_ff;
      end
      if (cmd.classify) begin
         frac_ff     <= '0;
         scan_idx_ff <= KEY_W'(1);
         prev_ff     <= t0_ff;
         if (le_first) begin
            lo_ff <= '0;
            hi_ff <= '0;
         end else begin
            lo_ff <= key_last_ff;
            hi_ff <= key_last_ff;
         end
      end
      if (cmd.scan_next) begin
         prev_ff     <= tdata_ff;
         scan_idx_ff <= scan_idx_ff + KEY_W'(1);
      end
      if (cmd.div_init) begin
         hi_ff      <= scan_idx_ff;
         lo_ff      <= scan_idx_ff - KEY_W'(1);
         rem_ff     <= query_ff - prev_ff;
         den_ff     <= tdata_ff - prev_ff;
         frac_ff    <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         if (rem_fits) begin
            rem_ff <= TIME_W'(rem_shift - {1'b0, den_ff});
         end else begin
            rem_ff <= rem_shift[TIME_W-1:0];
         end
         frac_ff    <= {frac_ff[FRAC_W-2:0], rem_fits};
         div_cnt_ff <= div_cnt_ff + DCNT_W'(1);
      end
      if (cmd.tgt_clear) begin
         tgt_ff <= '0;
      end
      if (cmd.tgt_next) begin
         tgt_ff <= tgt_ff + TGT_W'(1);
      end
   end

   // Interpolation: difference, then product, then the floor-shifted sum.
   always_ff @(posedge clock) begin
      if (cmd.latch_a) begin
         a_ff <= wdata_ff;
      end
      if (cmd.latch_diff) begin
         diff_ff <= {wdata_ff[WEIGHT_W-1], wdata_ff} - {a_ff[WEIGHT_W-1], a_ff};
      end
      if (cmd.mul) begin
         prod_ff <= (WEIGHT_W+FRAC_W+2)'(diff_ff) *
                    (WEIGHT_W+FRAC_W+2)'($signed({1'b0, frac_ff}));
      end
   end

   assign prod_shift = prod_ff >>> FRAC_W;
   assign result = {{2{a_ff[WEIGHT_W-1]}}, a_ff} + prod_shift[WEIGHT_W+1:0];

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         weight_out_ff <= result[WEIGHT_W-1:0];
         target_out_ff <= TIDX_W'(tgt_ff);
         last_ff       <= (tgt_ff == tgt_last_ff);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.weight_out = weight_out_ff;
   assign rsp_ch.target_out = target_out_ff;
   assign rsp_ch.last       = last_ff;

   assign status.interp      = !le_first && !ge_last;
   assign status.scan_hit    = (tdata_ff > query_ff) || (scan_idx_ff == key_last_ff);
   assign status.div_done    = (div_cnt_ff == DIV_LAST);
   assign status.last_target = (tgt_ff == tgt_last_ff);
   assign status.out_free    = !rsp_valid_ff || rsp_ch.ready;

`ifndef NO_ASSERTIONS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < den_ff)
      else $error("divider remainder reached the divisor");

   a_clamped_no_frac: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && (lo_ff == hi_ff) |-> frac_ff == '0)
      else $error("nonzero fraction on a clamped sample");
`endif

endmodule

// ===== src/kws_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe weight sampler controller
// Sequences loads, the keyframe search, the fraction divide and the
// per-target interpolation.
// ----------------------------------------------------------------------------
module kws_controller import kws_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [FUNC_W-1:0] req_func,
   output logic              req_ready,
   input  kws_status_type    status,
   output kws_cmd_type       cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_FIRST,
      S_RD_LAST,
      S_CHECK,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DIV,
      S_RD_A,
      S_RD_B,
      S_DIFF,
      S_MUL,
      S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_func)
                  FUNC_LOAD_TIME:   cmd.load_time = 1'b1;
                  FUNC_LOAD_WEIGHT: cmd.load_weight = 1'b1;
                  FUNC_SAMPLE: begin
                     cmd.capture = 1'b1;
                     state_in    = S_RD_FIRST;
                  end
                  default: ;
               endcase
            end
         end
         S_RD_FIRST: begin
            cmd.taddr_sel = TADDR_FIRST;
            state_in      = S_RD_LAST;
         end
         S_RD_LAST: begin
            cmd.taddr_sel  = TADDR_LAST;
            cmd.keep_first = 1'b1;
            state_in       = S_CHECK;
         end
         S_CHECK: begin
            cmd.classify = 1'b1;
            if (status.interp) begin
               state_in = S_SCAN_RD;
            end else begin
               cmd.tgt_clear = 1'b1;
               state_in      = S_RD_A;
            end
         end
         S_SCAN_RD: begin
            cmd.taddr_sel = TADDR_SCAN;
            state_in      = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (status.scan_hit) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               cmd.tgt_clear = 1'b1;
               state_in      = S_RD_A;
            end
         end
         S_RD_A: begin
            state_in = S_RD_B;
         end
         S_RD_B: begin
            cmd.w_sel_hi = 1'b1;
            cmd.latch_a  = 1'b1;
            state_in     = S_DIFF;
         end
         S_DIFF: begin
            cmd.latch_diff = 1'b1;
            state_in       = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               if (status.last_target) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.tgt_next = 1'b1;
                  state_in     = S_RD_A;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && status.last_target |=> req_ready)
      else $error("not ready after the final result of a sample");

   a_busy_after_sample: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_func == FUNC_SAMPLE) |=> !req_ready)
      else $error("ready during a sample");
`endif

endmodule

// ===== src/keyframe_weight_sampler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyframe weight sampler core
// Linear keyframe interpolation of morph target weights over a loaded table
// of keyframe times and per-keyframe weights.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake      carries
//   req_ch    in          valid/ready    func, key_index, target_index,
//                                        time_value, weight_value
//   rsp_ch    out         valid/ready    weight_out, target_out, last
//   csr_*     in          write enable   num_keyframes, num_targets
//
// A load item writes the time or weight memory directly as it is accepted.
// A sample item reads the first and last keyframe times; in the interpolating
// case it then scans keyframe times, divides out the fraction and, for each
// target, reads two weights and multiplies; at or outside the ends it skips
// the scan and divide. The time is set by the single read port of the time
// memory (a read state and a check state per scanned keyframe), the
// one-bit-per-cycle divider, and the weight port plus multiplier per target.
// Reset is synchronous and clears the controller, the register settings and
// the result valid; the memory contents are undefined until loaded.
// A stalled result holds in the output register; the next item is accepted
// once the final result of a sample sits in that register.
// ----------------------------------------------------------------------------
module keyframe_weight_sampler_core import kws_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   kws_req_if.sink          req_ch,
   kws_rsp_if.source        rsp_ch,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_write_data
);

   kws_cmd_type    cmd;
   kws_status_type status;

   // The controller owns the request handshake; the datapath owns the
   // result register and the memories.
   kws_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_func  (req_ch.func),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   kws_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_key_index    (req_ch.key_index),
      .req_target_index (req_ch.target_index),
      .req_time_value   (req_ch.time_value),
      .req_weight_value (req_ch.weight_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_ch           (rsp_ch)
   );

endmodule
